// File: sv/assert_macros.svh
// assertion macros for the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/pma_pkg.sv
`timescale 1ns / 1ps
// types and constants for the polynomial multiply/add/sub block
// used by pma_ctrl, pma_dp and the top level
package pma_pkg;

    localparam int MAX_TERMS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int COEF_W        = 32;
    localparam int POW_W         = 6;
    localparam int MODE_W        = 2;
    localparam int ADDR_W        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W         = ADDR_W + 1;
    localparam int PROD_W        = 2 * COEF_W;
    localparam int ACC_W         = PROD_W + ADDR_W;

    localparam logic [MODE_W-1:0] MODE_MUL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WAIT_OUT,
        S_ISSUE,
        S_WAIT_RES
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic              in_ready;
        logic              issue;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic              first;
        logic              last;
        logic [CNT_W-1:0]  k;
        logic              final_term;
        logic              clr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic              is_mul;
        logic [CNT_W-1:0]  cnt1;
        logic [CNT_W-1:0]  cnt2;
        logic              res_done;
        logic              out_busy;
    } t_status;

endpackage

// File: sv/polynomial_multiply_add_sub.sv
`timescale 1ns / 1ps
// top level of the polynomial multiply/add/sub block
// depends on pma_pkg, pma_ctrl, pma_dp and assert_macros.svh
//
// Input channel (i_in_valid / o_in_ready): one coefficient beat per cycle,
// first operand lowest power first, then the second operand. A beat of the
// second operand with i_last_term set starts the operation; until every
// result term has been formed o_in_ready stays low. Surplus terms beyond
// 32 per operand are dropped and flag o_overflow on every result beat.
// Output channel (o_out_valid / i_out_ready): one beat per result term,
// lowest power first, o_last_result on the final one.
// Cost: each result term runs through the single multiply-accumulate pipe
// (memory read, multiply, accumulate) once per product that it sums; an
// add or subtract has one sum per term. Coefficient beats that do not
// start an operation are taken one per cycle. A stalled receiver holds
// the output register; the next term is not started until the previous
// one has been taken. Reset (synchronous, active low) clears the counts,
// the drop flag and the mode register (multiply). Mode is written through
// i_cfg_we; the user must write it only while idle, as the block itself
// does not enforce this.
`include "assert_macros.svh"

module polynomial_multiply_add_sub
    import pma_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [MODE_W-1:0]        i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_which_operand,
    input  logic signed [COEF_W-1:0] i_coefficient,
    input  logic                     i_last_term,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [COEF_W-1:0] o_result_coefficient,
    output logic [POW_W-1:0]         o_power,
    output logic                     o_last_result,
    output logic                     o_overflow
);

    t_cmd    cmd;
    t_status status;

    pma_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_which_operand (i_which_operand),
        .i_last_term     (i_last_term),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    pma_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .i_which_operand      (i_which_operand),
        .i_coefficient        (i_coefficient),
        .i_cmd                (cmd),
        .i_out_ready          (i_out_ready),
        .o_status             (status),
        .o_out_valid          (o_out_valid),
        .o_result_coefficient (o_result_coefficient),
        .o_power              (o_power),
        .o_last_result        (o_last_result),
        .o_overflow           (o_overflow)
    );

    assign o_in_ready = cmd.in_ready;

    // products are only issued while the output register is empty
    `ASSERT_SAME(a_issue_out_empty, i_clk, i_rst_n, cmd.issue, !status.out_busy)
    // a finished term never lands on a pending result
    `ASSERT_SAME(a_load_out_empty, i_clk, i_rst_n, status.res_done, !o_out_valid)
    `ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, status.res_done, o_out_valid)
    // pipe is drained whenever input beats are taken
    `ASSERT_SAME(a_idle_drained, i_clk, i_rst_n, i_in_valid && o_in_ready,
                 !status.res_done && !cmd.issue)

endmodule

// File: sv/pma_dp.sv
`timescale 1ns / 1ps
// datapath: operand memories, counts, multiply-accumulate pipeline, output register
// depends on pma_pkg
module pma_dp
    import pma_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [MODE_W-1:0]        i_cfg_wdata,
    input  logic                     i_in_valid,
    input  logic                     i_which_operand,
    input  logic signed [COEF_W-1:0] i_coefficient,
    input  t_cmd                     i_cmd,
    input  logic                     i_out_ready,
    output t_status                  o_status,
    output logic                     o_out_valid,
    output logic signed [COEF_W-1:0] o_result_coefficient,
    output logic [POW_W-1:0]         o_power,
    output logic                     o_last_result,
    output logic                     o_overflow
);

    logic signed [COEF_W-1:0] r_mem_a [MAX_TERMS];
    logic signed [COEF_W-1:0] r_mem_b [MAX_TERMS];

    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]  r_cnt1;
    logic [CNT_W-1:0]  r_cnt2;
    logic              r_dropped;

    // stage 1: memory read
    logic signed [COEF_W-1:0] r_a_rd;
    logic signed [COEF_W-1:0] r_b_rd;
    logic                     r_s1_valid;
    logic                     r_s1_first;
    logic                     r_s1_last;
    logic                     r_s1_mask_a;
    logic                     r_s1_mask_b;
    logic [CNT_W-1:0]         r_s1_k;
    logic                     r_s1_final;

    // stage 2: product or sum
    logic signed [PROD_W-1:0] r_s2_val;
    logic signed [PROD_W-1:0] n_s2_val;
    logic                     r_s2_valid;
    logic                     r_s2_first;
    logic                     r_s2_last;
    logic [CNT_W-1:0]         r_s2_k;
    logic                     r_s2_final;

    // stage 3: accumulate
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [COEF_W-1:0] sat_val;
    logic                     sat_ov;

    logic                     r_out_valid;
    logic signed [COEF_W-1:0] r_out_coef;
    logic [POW_W-1:0]         r_out_pow;
    logic                     r_out_last;
    logic                     r_out_ov;

    logic                     accept;
    logic                     is_mul;
    logic                     is_add;
    logic signed [COEF_W-1:0] a_eff;
    logic signed [COEF_W-1:0] b_eff;
    logic                     load_out;

    assign accept   = i_cmd.in_ready & i_in_valid;
    assign is_mul   = (r_mode == MODE_MUL);
    assign is_add   = (r_mode == MODE_ADD);
    assign load_out = r_s2_valid & r_s2_last;

    // config, counts and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_MUL;
            r_cnt1    <= '0;
            r_cnt2    <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_cnt1    <= '0;
                r_cnt2    <= '0;
                r_dropped <= 1'b0;
            end else if (accept) begin
                if (!i_which_operand) begin
                    if (r_cnt1 < CNT_W'(MAX_TERMS)) begin
                        r_cnt1 <= r_cnt1 + CNT_W'(1);
                    end else begin
                        r_dropped <= 1'b1;
                    end
                end else begin
                    if (r_cnt2 < CNT_W'(MAX_TERMS)) begin
                        r_cnt2 <= r_cnt2 + CNT_W'(1);
                    end else begin
                        r_dropped <= 1'b1;
                    end
                end
            end
        end
    end

    // operand memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (accept && !i_which_operand && (r_cnt1 < CNT_W'(MAX_TERMS))) begin
            r_mem_a[r_cnt1[ADDR_W-1:0]] <= i_coefficient;
        end
        if (accept && i_which_operand && (r_cnt2 < CNT_W'(MAX_TERMS))) begin
            r_mem_b[r_cnt2[ADDR_W-1:0]] <= i_coefficient;
        end
        r_a_rd <= r_mem_a[i_cmd.addr_a];
        r_b_rd <= r_mem_b[i_cmd.addr_b];
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_first  <= i_cmd.first;
        r_s1_last   <= i_cmd.last;
        r_s1_k      <= i_cmd.k;
        r_s1_final  <= i_cmd.final_term;
        // terms past an operand's count read as zero
        r_s1_mask_a <= ({1'b0, i_cmd.addr_a} < r_cnt1);
        r_s1_mask_b <= ({1'b0, i_cmd.addr_b} < r_cnt2);
        r_s2_val    <= n_s2_val;
        r_s2_first  <= r_s1_first;
        r_s2_last   <= r_s1_last;
        r_s2_k      <= r_s1_k;
        r_s2_final  <= r_s1_final;
        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        a_eff = r_s1_mask_a ? r_a_rd : '0;
        b_eff = r_s1_mask_b ? r_b_rd : '0;
        if (is_mul) begin
            n_s2_val = a_eff * b_eff;
        end else if (is_add) begin
            n_s2_val = PROD_W'(a_eff) + PROD_W'(b_eff);
        end else begin
            n_s2_val = PROD_W'(a_eff) - PROD_W'(b_eff);
        end
    end

    // accumulate, drop fraction bits (floor) in multiply mode only, saturate
    always_comb begin
        if (r_s2_first) begin
            n_acc = ACC_W'(r_s2_val);
        end else begin
            n_acc = r_acc + ACC_W'(r_s2_val);
        end
        shifted = is_mul ? (n_acc >>> FRACTION_BITS) : n_acc;
        if ((&shifted[ACC_W-1:COEF_W-1]) || !(|shifted[ACC_W-1:COEF_W-1])) begin
            sat_val = shifted[COEF_W-1:0];
            sat_ov  = 1'b0;
        end else begin
            sat_val = shifted[ACC_W-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                       : {1'b0, {(COEF_W-1){1'b1}}};
            sat_ov  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_coef <= sat_val;
            r_out_pow  <= POW_W'(r_s2_k);
            r_out_last <= r_s2_final;
            r_out_ov   <= sat_ov | r_dropped;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_result_coefficient = r_out_coef;
    assign o_power              = r_out_pow;
    assign o_last_result        = r_out_last;
    assign o_overflow           = r_out_ov;

    assign o_status.is_mul   = is_mul;
    assign o_status.cnt1     = r_cnt1;
    assign o_status.cnt2     = r_cnt2;
    assign o_status.res_done = load_out;
    assign o_status.out_busy = r_out_valid;

endmodule

// File: sv/pma_ctrl.sv
`timescale 1ns / 1ps
// controller: input acceptance and term/product sequencing
// depends on pma_pkg
module pma_ctrl
    import pma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_which_operand,
    input  logic    i_last_term,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_jhi, n_jhi;
    logic             r_first, n_first;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_n1, n_n1;
    logic [CNT_W-1:0] r_n2, n_n2;

    logic [CNT_W-1:0] len1;
    logic [CNT_W-1:0] len2;
    logic [CNT_W-1:0] j_lo;
    logic [CNT_W-1:0] j_hi;
    logic [CNT_W-1:0] diff;
    logic             final_term;
    logic             is_last_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_j     <= n_j;
        r_jhi   <= n_jhi;
        r_first <= n_first;
        r_n     <= n_n;
        r_n1    <= n_n1;
        r_n2    <= n_n2;
    end

    // an empty operand counts as one zero term
    assign len1       = (i_status.cnt1 == '0) ? CNT_W'(1) : i_status.cnt1;
    assign len2       = (i_status.cnt2 == '0) ? CNT_W'(1) : i_status.cnt2;
    assign final_term = (r_k == r_n - CNT_W'(1));
    assign is_last_j  = (r_j == r_jhi);
    assign diff       = r_k - r_j;

    // product index range for output term k
    always_comb begin
        if (i_status.is_mul) begin
            j_lo = (r_k >= r_n2) ? (r_k - r_n2 + CNT_W'(1)) : '0;
            j_hi = (r_k < r_n1) ? r_k : (r_n1 - CNT_W'(1));
        end else begin
            j_lo = r_k;
            j_hi = r_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        n_jhi   = r_jhi;
        n_first = r_first;
        n_n     = r_n;
        n_n1    = r_n1;
        n_n2    = r_n2;

        o_cmd            = '0;
        o_cmd.addr_a     = r_j[ADDR_W-1:0];
        o_cmd.addr_b     = i_status.is_mul ? diff[ADDR_W-1:0] : r_k[ADDR_W-1:0];
        o_cmd.first      = r_first;
        o_cmd.last       = is_last_j;
        o_cmd.k          = r_k;
        o_cmd.final_term = final_term;

        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid && i_which_operand && i_last_term) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_n1 = len1;
                n_n2 = len2;
                if (i_status.is_mul) begin
                    n_n = len1 + len2 - CNT_W'(1);
                end else begin
                    n_n = (len1 > len2) ? len1 : len2;
                end
                n_k     = '0;
                n_state = S_WAIT_OUT;
            end
            S_WAIT_OUT: begin
                if (!i_status.out_busy) begin
                    n_j     = j_lo;
                    n_jhi   = j_hi;
                    n_first = 1'b1;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_first     = 1'b0;
                if (is_last_j) begin
                    n_state = S_WAIT_RES;
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
            end
            S_WAIT_RES: begin
                if (i_status.res_done) begin
                    if (final_term) begin
                        o_cmd.clr = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_WAIT_OUT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: dv/poly_result_checker.sv
`timescale 1ns / 1ps
// result checker for polynomial_multiply_add_sub: watches the mode writes and both
// beat channels, predicts every result coefficient and compares it field by field
// depends on pma_pkg
module poly_result_checker
    import pma_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [MODE_W-1:0]        i_cfg_wdata,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_which_operand,
    input  logic signed [COEF_W-1:0] i_coefficient,
    input  logic                     i_last_term,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [COEF_W-1:0] i_result_coefficient,
    input  logic [POW_W-1:0]         i_power,
    input  logic                     i_last_result,
    input  logic                     i_overflow,
    output int                       o_mismatch_count,
    output int                       o_terms_pending
);

    localparam int     MAX_REPORTS = 10;
    localparam longint COEF_MAX    = 64'sd2147483647;
    localparam longint COEF_MIN    = -COEF_MAX - 1;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [POW_W-1:0]         power;
        logic                     last;
        logic                     overflow;
    } t_result_term;

    logic signed [COEF_W-1:0] first_store [MAX_TERMS];
    logic signed [COEF_W-1:0] second_store[MAX_TERMS];
    int                       first_len;
    int                       second_len;
    logic                     terms_dropped;
    logic [MODE_W-1:0]        mode_q;
    t_result_term             expected_terms[$];
    int                       n_fail;

    function automatic longint coef_at(input logic signed [COEF_W-1:0] store[MAX_TERMS],
                                       input int len, input int idx);
        if (idx < len)
            return longint'(store[idx]);
        return 0;
    endfunction

    function automatic logic signed [COEF_W-1:0] clamp_coef(input logic signed [79:0] v,
                                                            output logic ov);
        ov = 1'b0;
        if (v > COEF_MAX) begin
            ov = 1'b1;
            return {1'b0, {(COEF_W-1){1'b1}}};
        end
        if (v < COEF_MIN) begin
            ov = 1'b1;
            return {1'b1, {(COEF_W-1){1'b0}}};
        end
        return v[COEF_W-1:0];
    endfunction

    // forms all result terms of one operation and clears the operand stores
    function automatic void predict_result_terms();
        int                 n1;
        int                 n2;
        int                 n;
        logic signed [79:0] acc;
        longint             diff;
        logic               ov;
        t_result_term       t;
        n1 = (first_len == 0) ? 1 : first_len;
        n2 = (second_len == 0) ? 1 : second_len;
        n  = (mode_q == MODE_MUL) ? n1 + n2 - 1 : ((n1 > n2) ? n1 : n2);
        for (int k = 0; k < n; k++) begin
            if (mode_q == MODE_MUL) begin
                acc = '0;
                for (int j = 0; j <= k; j++) begin
                    if (j < n1 && k - j < n2)
                        acc += 80'(coef_at(first_store, first_len, j) *
                                   coef_at(second_store, second_len, k - j));
                end
                // exact sum, then truncate toward minus infinity
                t.coef = clamp_coef(acc >>> FRACTION_BITS, ov);
            end else begin
                // mode 3 falls through to subtract
                if (mode_q == MODE_ADD)
                    diff = coef_at(first_store, first_len, k) +
                           coef_at(second_store, second_len, k);
                else
                    diff = coef_at(first_store, first_len, k) -
                           coef_at(second_store, second_len, k);
                t.coef = clamp_coef(80'(diff), ov);
            end
            t.power    = k[POW_W-1:0];
            t.last     = (k == n - 1);
            t.overflow = ov | terms_dropped;
            expected_terms.push_back(t);
        end
        first_len     = 0;
        second_len    = 0;
        terms_dropped = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_result_term t;
        if (!i_rst_n) begin
            first_len     = 0;
            second_len    = 0;
            terms_dropped = 1'b0;
            mode_q        = MODE_MUL;
            n_fail        = 0;
            expected_terms.delete();
        end else begin
            if (i_cfg_we)
                mode_q = i_cfg_wdata;

            if (i_out_valid && i_out_ready) begin
                if (expected_terms.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("%0t: unexpected result beat coef %h pow %0d last %b ovf %b",
                                 $time, i_result_coefficient, i_power, i_last_result,
                                 i_overflow);
                end else begin
                    t = expected_terms.pop_front();
                    if (i_result_coefficient !== t.coef || i_power !== t.power ||
                        i_last_result !== t.last || i_overflow !== t.overflow) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS)
                            $display({"%0t: result beat mismatch: expected coef %h pow %0d ",
                                      "last %b ovf %b, got coef %h pow %0d last %b ovf %b"},
                                     $time, t.coef, t.power, t.last, t.overflow,
                                     i_result_coefficient, i_power, i_last_result,
                                     i_overflow);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (!i_which_operand) begin
                    if (first_len < MAX_TERMS) begin
                        first_store[first_len] = i_coefficient;
                        first_len++;
                    end else begin
                        terms_dropped = 1'b1;
                    end
                end else begin
                    if (second_len < MAX_TERMS) begin
                        second_store[second_len] = i_coefficient;
                        second_len++;
                    end else begin
                        terms_dropped = 1'b1;
                    end
                    // a dropped term with last_term still starts the operation
                    if (i_last_term)
                        predict_result_terms();
                end
            end
        end
        o_mismatch_count <= n_fail;
        o_terms_pending  <= expected_terms.size();
    end

endmodule

// File: dv/tb_polynomial_multiply_add_sub.sv
`timescale 1ns / 1ps
// top of the polynomial_multiply_add_sub testbench: clock, reset, mode writes,
// coefficient beats and random stalls; depends on pma_pkg and poly_result_checker
module tb_polynomial_multiply_add_sub;
    import pma_pkg::*;

    localparam int                WATCHDOG_LIMIT = 5000;
    localparam int                RANDOM_BEATS   = 180;
    localparam int                DRAIN_CYCLES   = 16;
    localparam logic [MODE_W-1:0] MODE_SUB_ALT   = 2'd3;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_cfg_we        = 1'b0;
    logic [MODE_W-1:0]        i_cfg_wdata     = '0;
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_ready;
    logic                     i_which_operand = 1'b0;
    logic signed [COEF_W-1:0] i_coefficient   = '0;
    logic                     i_last_term     = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready     = 1'b0;
    logic signed [COEF_W-1:0] o_result_coefficient;
    logic [POW_W-1:0]         o_power;
    logic                     o_last_result;
    logic                     o_overflow;

    int mismatch_count;
    int terms_pending;
    int coef_beats;
    bit no_idle;

    polynomial_multiply_add_sub u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_which_operand      (i_which_operand),
        .i_coefficient        (i_coefficient),
        .i_last_term          (i_last_term),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_result_coefficient (o_result_coefficient),
        .o_power              (o_power),
        .o_last_result        (o_last_result),
        .o_overflow           (o_overflow)
    );

    poly_result_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .i_in_ready           (o_in_ready),
        .i_which_operand      (i_which_operand),
        .i_coefficient        (i_coefficient),
        .i_last_term          (i_last_term),
        .i_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .i_result_coefficient (o_result_coefficient),
        .i_power              (o_power),
        .i_last_result        (o_last_result),
        .i_overflow           (o_overflow),
        .o_mismatch_count     (mismatch_count),
        .o_terms_pending      (terms_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // valid stays up between back-to-back beats, so it is only lowered before a gap
    task automatic send_beat(input logic which, input logic [COEF_W-1:0] coef,
                             input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_which_operand <= which;
        i_coefficient   <= coef;
        i_last_term     <= last;
        do @(posedge i_clk); while (!o_in_ready);
        coef_beats++;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (terms_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0001_0000;
                    default: return 32'h0000_0000;
                endcase
            end
            // within +/-4.0 so that products mostly stay in range
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    function automatic int pick_len(input int min_len);
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(28, 34);
        return $urandom_range(min_len, 5);
    endfunction

    // the second operand always ends with last_term; the first gets it at random too
    task automatic send_operand(input logic which, input int len);
        logic last;
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            if (!which && $urandom_range(0, 3) == 0)
                last = 1'($urandom_range(0, 1));
            send_beat(which, rand_coef(), last);
        end
    endtask

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        logic [MODE_W-1:0] phase_mode;
        int                phase;
        int                n_ops;
        no_idle    = 1'b0;
        coef_beats = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // multiply: saturation both ways from the extreme coefficients
        write_mode(MODE_MUL);
        send_beat(1'b0, 32'h7FFF_FFFF, 1'b0);
        send_beat(1'b0, 32'h8000_0000, 1'b1);
        send_beat(1'b1, 32'h8000_0000, 1'b0);
        send_beat(1'b1, 32'h7FFF_FFFF, 1'b1);
        // empty first operand counts as zero
        send_beat(1'b1, 32'h0001_8000, 1'b1);
        // last_term on the first operand only stores; truncation toward minus infinity
        send_beat(1'b0, 32'h0002_0000, 1'b1);
        send_beat(1'b0, 32'hFFFF_8000, 1'b1);
        send_beat(1'b1, 32'hFFFF_FFFF, 1'b0);
        send_beat(1'b1, 32'h0000_0001, 1'b1);
        wait_results_drained();

        // add with unequal lengths and a positive saturation
        write_mode(MODE_ADD);
        send_beat(1'b0, 32'h7FFF_FFFF, 1'b0);
        send_beat(1'b0, 32'h0000_0001, 1'b0);
        send_beat(1'b0, 32'h0000_0002, 1'b1);
        send_beat(1'b1, 32'h0000_0001, 1'b1);
        wait_results_drained();

        // subtract saturating low, and zero minus the most negative value
        write_mode(MODE_SUB);
        send_beat(1'b0, 32'h8000_0000, 1'b1);
        send_beat(1'b1, 32'h0000_0001, 1'b0);
        send_beat(1'b1, 32'h8000_0000, 1'b1);
        wait_results_drained();

        // mode 3 acts as subtract
        write_mode(MODE_SUB_ALT);
        send_beat(1'b0, 32'h0001_0000, 1'b1);
        send_beat(1'b1, 32'h0003_0000, 1'b1);
        send_beat(1'b1, 32'h0000_0005, 1'b1);
        wait_results_drained();

        coef_beats = 0;
        phase      = 0;
        while (coef_beats < RANDOM_BEATS) begin
            case (phase)
                0:       phase_mode = MODE_MUL;
                1:       phase_mode = MODE_ADD;
                2:       phase_mode = MODE_SUB;
                3:       phase_mode = MODE_SUB_ALT;
                default: phase_mode = MODE_W'($urandom_range(0, 3));
            endcase
            write_mode(phase_mode);
            no_idle = (phase % 3 == 2);
            if (phase == 0) begin
                // both operands overfull: dropped terms and the longest product
                send_operand(1'b0, 34);
                send_operand(1'b1, 33);
            end
            n_ops = $urandom_range(2, 4);
            for (int op = 0; op < n_ops; op++) begin
                send_operand(1'b0, pick_len(0));
                send_operand(1'b1, pick_len(1));
            end
            wait_results_drained();
            phase++;
        end
        no_idle = 1'b0;

        if (mismatch_count == 0 && terms_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: polynomial_multiply_add_sub.f
+incdir+sv
sv/pma_pkg.sv
sv/pma_dp.sv
sv/pma_ctrl.sv
sv/polynomial_multiply_add_sub.sv
dv/poly_result_checker.sv
dv/tb_polynomial_multiply_add_sub.sv
